@@ hdl/nps_pkg.sv @@
package nps_pkg;

   // Job table geometry
   localparam int NUM_JOBS = 16;
   localparam int IDX_W    = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;

   // Field widths fixed by the item format
   localparam int ARR_W   = 16;
   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int SLOT_W  = 4;
   localparam int CLK_W   = 32;
   localparam int WIDE_W  = 9;

   localparam logic [CLK_W-1:0] CLOCK_MAX = '1;

   // Request codes
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // One job table entry as stored in memory
   typedef struct packed {
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] remaining;
      logic [PRIO_W-1:0]  priority_val;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_WRITE
   } state_type;

endpackage

@@ hdl/nonpreemptive_priority_scheduler_unit.sv @@
// Non-preemptive priority scheduler over a table of NUM_JOBS job slots.
// Request channel: present req_kind and its fields with start high; the
// transaction is taken at a rising edge where start is high and busy is low.
//   load  : writes arrival, burst and priority into req_slot, no response.
//           Slots at or above NUM_JOBS are dropped.
//   clear : empties the table, stops the running job, zeroes the clock,
//           no response. Code 3 is ignored.
//   tick  : runs one time unit and returns exactly one response.
// Response channel: rsp_strobe is high for one cycle with rsp_job, rsp_idle,
// rsp_all_done and rsp_tick_time; the receiver cannot stall it, it must
// capture the transaction in that cycle.
// Tick sequence: while a job keeps running, busy stays high after acceptance
// for one table read and one write back of that job (S_DRAIN, S_WRITE), and
// the response shows in the cycle after the write back. When a new job must
// be chosen, the table memory is read one slot per cycle in S_SCAN over all
// NUM_JOBS slots before S_DRAIN and S_WRITE. The single read port of the
// job table sets the length of this scan.
// Reset clears the slot occupancy flags, the running job and the clock;
// no memory sweep is needed.
module nonpreemptive_priority_scheduler_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_kind,
   input  logic [nps_pkg::SLOT_W-1:0]  req_slot,
   input  logic [nps_pkg::ARR_W-1:0]   req_arrival_time,
   input  logic [nps_pkg::BURST_W-1:0] req_burst_time,
   input  logic [nps_pkg::PRIO_W-1:0]  req_priority_req,
   output logic                        rsp_strobe,
   output logic [nps_pkg::SLOT_W-1:0]  rsp_job,
   output logic                        rsp_idle,
   output logic                        rsp_all_done,
   output logic [nps_pkg::CLK_W-1:0]   rsp_tick_time
);

   import nps_pkg::*;

   // Control state
   state_type             state_ff, state_in;
   logic [NUM_JOBS-1:0]   work_ff, work_in;
   logic                  run_valid_ff, run_valid_in;
   logic [IDX_W-1:0]      run_job_ff, run_job_in;
   logic [CLK_W-1:0]      clock_ff, clock_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  found_ff, found_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;

   // Payload registers
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  rd_force_ff, rd_force_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   entry_type             best_ff, best_in;
   logic [SLOT_W-1:0]     rsp_job_ff, rsp_job_in;
   logic                  rsp_idle_ff, rsp_idle_in;
   logic                  rsp_all_done_ff, rsp_all_done_in;
   logic [CLK_W-1:0]      rsp_time_ff, rsp_time_in;

   // Memory ports
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_data;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [ENTRY_W-1:0]    rd_word;
   entry_type             rd_data;

   // Request decode
   logic                  accept;
   logic [WIDE_W-1:0]     slot_wide;
   logic                  slot_ok;
   logic [IDX_W-1:0]      slot_idx;
   logic                  keep_running;

   // Selection and write back
   logic                  eligible;
   logic                  take;
   logic [BURST_W-1:0]    rem_dec;
   logic [NUM_JOBS-1:0]   work_upd;
   logic [WIDE_W-1:0]     best_wide;

   nps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_JOBS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_data = entry_type'(rd_word);

   // Decode the incoming transaction
   assign accept       = start && (state_ff == S_IDLE);
   assign busy         = (state_ff != S_IDLE);
   assign slot_wide    = WIDE_W'(req_slot);
   assign slot_ok      = (slot_wide < WIDE_W'(NUM_JOBS));
   assign slot_idx     = slot_wide[IDX_W-1:0];
   assign keep_running = run_valid_ff && work_ff[run_job_ff];

   // Compare the entry read last cycle against the best so far
   assign eligible = rd_vld_ff && work_ff[rd_idx_ff] &&
                     (rd_force_ff || ({{(CLK_W-ARR_W){1'b0}}, rd_data.arrival} <= clock_ff));
   assign take     = eligible && (!found_ff || (rd_data.priority_val < best_ff.priority_val));

   // Spend one unit of the chosen job
   assign rem_dec   = best_ff.remaining - BURST_W'(1);
   assign best_wide = WIDE_W'(best_idx_ff);

   always_comb begin
      work_upd = work_ff;
      if (found_ff) begin
         work_upd[best_idx_ff] = (rem_dec != '0);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_kind == KIND_TICK)) begin
               state_in = keep_running ? S_DRAIN : S_SCAN;
            end
         end
         S_SCAN: begin
            if (cnt_ff == IDX_W'(NUM_JOBS - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_WRITE;
         S_WRITE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs and datapath updates
   always_comb begin
      work_in         = work_ff;
      run_valid_in    = run_valid_ff;
      run_job_in      = run_job_ff;
      clock_in        = clock_ff;
      cnt_in          = cnt_ff;
      rd_vld_in       = 1'b0;
      rd_idx_in       = rd_idx_ff;
      rd_force_in     = rd_force_ff;
      found_in        = found_ff;
      best_idx_in     = best_idx_ff;
      best_in         = best_ff;
      rsp_strobe_in   = 1'b0;
      rsp_job_in      = rsp_job_ff;
      rsp_idle_in     = rsp_idle_ff;
      rsp_all_done_in = rsp_all_done_ff;
      rsp_time_in     = rsp_time_ff;
      wr_en           = 1'b0;
      wr_addr         = slot_idx;
      wr_data         = '{arrival: req_arrival_time, remaining: req_burst_time,
                          priority_val: req_priority_req};
      rd_en           = 1'b0;
      rd_addr         = cnt_ff;

      // Hold the best candidate seen so far
      if (take) begin
         found_in    = 1'b1;
         best_idx_in = rd_idx_ff;
         best_in     = rd_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_LOAD: begin
                     if (slot_ok) begin
                        wr_en             = 1'b1;
                        work_in[slot_idx] = (req_burst_time != '0);
                     end
                  end
                  KIND_TICK: begin
                     found_in = 1'b0;
                     cnt_in   = '0;
                     if (keep_running) begin
                        // Fetch the running job only
                        rd_en       = 1'b1;
                        rd_addr     = run_job_ff;
                        rd_vld_in   = 1'b1;
                        rd_idx_in   = run_job_ff;
                        rd_force_in = 1'b1;
                     end else begin
                        run_valid_in = 1'b0;
                        rd_force_in  = 1'b0;
                     end
                  end
                  KIND_CLEAR: begin
                     work_in      = '0;
                     run_valid_in = 1'b0;
                     run_job_in   = '0;
                     clock_in     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Issue one slot read per cycle
            rd_en     = 1'b1;
            rd_addr   = cnt_ff;
            rd_vld_in = 1'b1;
            rd_idx_in = cnt_ff;
            cnt_in    = cnt_ff + IDX_W'(1);
         end
         S_DRAIN: begin
         end
         S_WRITE: begin
            // Write back the spent unit and report the tick
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = best_idx_ff;
               wr_data = '{arrival: best_ff.arrival, remaining: rem_dec,
                           priority_val: best_ff.priority_val};
               work_in = work_upd;
               if (rem_dec == '0) begin
                  run_valid_in = 1'b0;
                  run_job_in   = '0;
               end else begin
                  run_valid_in = 1'b1;
                  run_job_in   = best_idx_ff;
               end
            end
            if (clock_ff != CLOCK_MAX) begin
               clock_in = clock_ff + CLK_W'(1);
            end
            rsp_strobe_in   = 1'b1;
            rsp_job_in      = found_ff ? best_wide[SLOT_W-1:0] : '0;
            rsp_idle_in     = !found_ff;
            rsp_all_done_in = (work_upd == '0);
            rsp_time_in     = clock_ff;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         work_ff       <= '0;
         run_valid_ff  <= 1'b0;
         run_job_ff    <= '0;
         clock_ff      <= '0;
         cnt_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         work_ff       <= work_in;
         run_valid_ff  <= run_valid_in;
         run_job_ff    <= run_job_in;
         clock_ff      <= clock_in;
         cnt_ff        <= cnt_in;
         rd_vld_ff     <= rd_vld_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff       <= rd_idx_in;
      rd_force_ff     <= rd_force_in;
      best_idx_ff     <= best_idx_in;
      best_ff         <= best_in;
      rsp_job_ff      <= rsp_job_in;
      rsp_idle_ff     <= rsp_idle_in;
      rsp_all_done_ff <= rsp_all_done_in;
      rsp_time_ff     <= rsp_time_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_job       = rsp_job_ff;
   assign rsp_idle      = rsp_idle_ff;
   assign rsp_all_done  = rsp_all_done_ff;
   assign rsp_tick_time = rsp_time_ff;

`ifndef SYNTH
   // A response never lasts more than one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for two cycles");

   // An accepted tick always keeps the block busy next cycle
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == KIND_TICK)) |=> busy)
      else $error("tick accepted but block not busy");

   // The chosen job must still have work when written back
   a_chosen_has_work: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_WRITE) && found_ff) |-> work_ff[best_idx_ff])
      else $error("selected job has no work left");

   // The clock only moves back on a clear or a reset
   a_clock_monotonic: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(accept && (req_kind == KIND_CLEAR)))
      |-> (clock_ff >= $past(clock_ff)))
      else $error("tick clock decreased without a clear");

   // A response appears only after a write back cycle
   a_strobe_after_write: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!$past(reset) && ($past(state_ff) == S_WRITE)))
      else $error("response without write back");
`endif

endmodule

@@ hdl/nps_ram.sv @@
module nps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
